// ----- design/bsc_pkg.sv -----
package bsc_pkg;

  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4
  } reg_idx_t;

  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] X3_BIAS    = 32'd32768;
  localparam logic [31:0] B7_SCALE   = 32'd50000;
  localparam logic [31:0] P_COEF_1   = 32'd3038;
  localparam logic [31:0] P_COEF_2   = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_BIAS     = 32'd3791;

  typedef struct packed {
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
  } cal_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic        sgn;     // signed truncating division
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    return 32'($signed(v) >>> n);
  endfunction

endpackage

// ----- design/bsc_stream_if.sv -----
interface bsc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] raw_reading;
  modport source (output valid, kind, raw_reading, input ready);
  modport sink (input valid, kind, raw_reading, output ready);
endinterface

// ----- design/bsc_out_if.sv -----
interface bsc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] compensated_value;
  logic        divide_error;
  modport source (output valid, result_kind, compensated_value, divide_error, input ready);
  modport sink (input valid, result_kind, compensated_value, divide_error, output ready);
endinterface

// ----- design/bsc_div.sv -----
module bsc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  bsc_pkg::div_req_t req,
  output bsc_pkg::div_rsp_t rsp
);
  import bsc_pkg::*;

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[31]};
    trial    = shifted - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      rem_nxt  = '0;
      if (req.sgn) begin
        quo_nxt = req.num[31] ? (32'd0 - req.num) : req.num;
        den_nxt = req.den[31] ? (32'd0 - req.den) : req.den;
        neg_nxt = req.num[31] ^ req.den[31];
      end else begin
        quo_nxt = req.num;
        den_nxt = req.den;
        neg_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? (32'd0 - quo_r) : quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without run");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> (cnt_r == 6'd0) || busy_r) else $error("divider count left over");
endmodule

// ----- design/bsc_seq.sv -----
module bsc_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  bsc_pkg::cal_t     cal,
  bsc_in_if.sink            in_ch,
  bsc_out_if.source         out_ch,
  output bsc_pkg::div_req_t dreq,
  input  bsc_pkg::div_rsp_t drsp
);
  import bsc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_DIVGO = 9'b000000100,
    S_DIVW  = 9'b000001000,
    S_POST  = 9'b000010000,
    S_OUT   = 9'b000100000,
    S_PMUL  = 9'b001000000,
    S_PDIVW = 9'b010000000,
    S_PFIN  = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] raw_r, raw_nxt;
  logic [31:0] b5_r, b5_nxt;
  // scratch registers
  logic [31:0] x1_r, x1_nxt, x2_r, x2_nxt, sq_r, sq_nxt, b3_r, b3_nxt;
  logic [31:0] b4_r, b4_nxt, b7_r, b7_nxt, p_r, p_nxt;
  logic [31:0] mp_r, mp_nxt;
  logic [31:0] res_r, res_nxt;
  logic        err_r, err_nxt;
  logic        ovld_r, ovld_nxt;
  logic [31:0] ma, mb, mprod;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, b6;
  assign ac1 = sx16(cal.ac1_ac2[31:16]);
  assign ac2 = sx16(cal.ac1_ac2[15:0]);
  assign ac3 = sx16(cal.ac3_ac4[31:16]);
  assign ac4 = {16'd0, cal.ac3_ac4[15:0]};
  assign ac5 = {16'd0, cal.ac5_ac6[31:16]};
  assign ac6 = {16'd0, cal.ac5_ac6[15:0]};
  assign b1  = sx16(cal.b1_b2[31:16]);
  assign b2  = sx16(cal.b1_b2[15:0]);
  assign mc  = sx16(cal.mc_md[31:16]);
  assign md  = sx16(cal.mc_md[15:0]);
  assign b6  = b5_r - B6_OFFSET;

  // operand select for the one shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_r == S_MUL) begin
      if (kind_r == 1'b0) begin
        ma = raw_r - ac6; mb = ac5;
      end else begin
        case (step_r)
          5'd0: begin ma = b6;  mb = b6;  end
          5'd1: begin ma = b2;  mb = sq_r; end
          5'd2: begin ma = ac2; mb = b6;  end
          5'd3: begin ma = ac3; mb = b6;  end
          5'd4: begin ma = b1;  mb = sq_r; end
          5'd5: begin ma = ac4; mb = mp_r; end
          5'd6: begin ma = raw_r - b3_r; mb = B7_SCALE; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
    end else if (state_r == S_PMUL) begin
      case (step_r)
        5'd0: begin ma = asr(p_r, 5'd8); mb = asr(p_r, 5'd8); end
        5'd1: begin ma = mp_r; mb = P_COEF_1; end
        5'd2: begin ma = P_COEF_2; mb = p_r; end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end
  assign mprod = 32'(ma * mb);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    kind_nxt  = kind_r;
    raw_nxt   = raw_r;
    b5_nxt    = b5_r;
    x1_nxt = x1_r; x2_nxt = x2_r; sq_nxt = sq_r; b3_nxt = b3_r;
    b4_nxt = b4_r; b7_nxt = b7_r; p_nxt = p_r; mp_nxt = mp_r;
    res_nxt  = res_r;
    err_nxt  = err_r;
    ovld_nxt = ovld_r;
    dreq     = '0;
    if (ovld_r && out_ch.ready) ovld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          raw_nxt   = {16'd0, in_ch.raw_reading};
          step_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        step_nxt = step_r + 5'd1;
        if (kind_r == 1'b0) begin
          x1_nxt    = asr(mprod, 5'd15);
          state_nxt = S_DIVGO;
        end else begin
          case (step_r)
            5'd0: sq_nxt = asr(mprod, 5'd12);
            5'd1: x1_nxt = asr(mprod, 5'd11);
            5'd2: begin
              x2_nxt = asr(mprod, 5'd11);
              b3_nxt = asr((ac1 << 2) + x1_r + asr(mprod, 5'd11) + 32'd2, 5'd2);
            end
            5'd3: x1_nxt = asr(mprod, 5'd13);
            5'd4: mp_nxt = asr(x1_r + asr(mprod, 5'd16) + 32'd2, 5'd2) + X3_BIAS;
            5'd5: b4_nxt = mprod >> 15;
            default: begin
              b7_nxt    = mprod;
              state_nxt = S_DIVGO;
            end
          endcase
        end
      end
      S_DIVGO: begin
        if (kind_r == 1'b0) begin
          x2_nxt = x1_r + md;
          if (x2_nxt == 32'd0) begin
            err_nxt = 1'b1; res_nxt = '0; state_nxt = S_OUT;
          end else begin
            dreq.start = 1'b1; dreq.sgn = 1'b1;
            dreq.num = mc << 11; dreq.den = x2_nxt;
            state_nxt = S_DIVW;
          end
        end else if (b4_r == 32'd0) begin
          err_nxt = 1'b1; res_nxt = '0; state_nxt = S_OUT;
        end else begin
          dreq.start = 1'b1; dreq.sgn = 1'b0;
          dreq.num = b7_r[31] ? b7_r : (b7_r << 1);
          dreq.den = b4_r;
          state_nxt = S_PDIVW;
        end
      end
      S_DIVW: begin
        if (drsp.done) begin
          b5_nxt    = x1_r + drsp.quo;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        res_nxt   = asr(b5_r + 32'd8, 5'd4);
        err_nxt   = 1'b0;
        state_nxt = S_OUT;
      end
      S_PDIVW: begin
        if (drsp.done) begin
          p_nxt     = b7_r[31] ? (drsp.quo << 1) : drsp.quo;
          step_nxt  = '0;
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: begin
        step_nxt = step_r + 5'd1;
        case (step_r)
          5'd0: mp_nxt = mprod;
          5'd1: x1_nxt = asr(mprod, 5'd16);
          default: begin
            x2_nxt    = asr(mprod, 5'd16);
            state_nxt = S_PFIN;
          end
        endcase
      end
      S_PFIN: begin
        res_nxt   = p_r + asr(x1_r + x2_r + P_BIAS, 5'd4);
        err_nxt   = 1'b0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovld_r || out_ch.ready) begin
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt; x1_r <= x1_nxt; x2_r <= x2_nxt; sq_r <= sq_nxt;
    b3_r <= b3_nxt; b4_r <= b4_nxt; b7_r <= b7_nxt; p_r <= p_nxt;
    mp_r <= mp_nxt; res_r <= res_nxt; err_r <= err_nxt;
    kind_r <= kind_nxt; step_r <= step_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
      b5_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      b5_r    <= b5_nxt;
    end
  end

  // result register holds one word so the next item starts while it waits
  logic        okind_r;
  logic [31:0] oval_r;
  logic        oerr_r;
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!ovld_r || out_ch.ready)) begin
      okind_r <= kind_r;
      oval_r  <= res_r;
      oerr_r  <= err_r;
    end
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = ovld_r;
  assign out_ch.result_kind       = okind_r;
  assign out_ch.compensated_value = oval_r;
  assign out_ch.divide_error      = oerr_r;

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == S_DIVW || state_r == S_PDIVW))
    else $error("quotient arrived outside a wait state");
  a_b5_only_temp: assert property (@(posedge clk) disable iff (!rst_n)
    (b5_r != $past(b5_r)) |-> $past(state_r == S_DIVW))
    else $error("b5 changed outside temperature path");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_ch.ready) |=> ovld_r && $stable(oval_r))
    else $error("pending result lost");
endmodule

// ----- design/barometric_sensor_compensation.sv -----
// Barometric sensor compensation: takes raw 16-bit temperature or pressure
// words and applies the integer datasheet compensation with oversampling
// zero. Calibration words are five 32-bit APB registers at 0x00..0x10.
// A temperature word yields 0.1 degC and stores b5 for later pressure words;
// a pressure word yields pascals. A zero divisor sets divide_error and value 0.
// One word is worked at a time through one shared 32x32 multiplier and one
// radix-2 divider of 32 steps; the multiply steps of a word run one by one.
// in_ready is high only while the sequencer is idle; a finished result sits in
// an output register so the next word may be taken before it is consumed.
module barometric_sensor_compensation (
  input  logic                          clk,
  input  logic                          rst_n,
  bsc_in_if.sink                        in_ch,
  bsc_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bsc_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import bsc_pkg::*;

  cal_t     cal_r;
  div_req_t dreq;
  div_rsp_t drsp;
  logic     wr_en;
  reg_idx_t widx;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign widx  = reg_idx_t'(cfg_paddr[4:2]);

  // calibration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (wr_en) begin
      case (widx)
        REG_AC1_AC2: cal_r.ac1_ac2 <= cfg_pwdata;
        REG_AC3_AC4: cal_r.ac3_ac4 <= cfg_pwdata;
        REG_AC5_AC6: cal_r.ac5_ac6 <= cfg_pwdata;
        REG_B1_B2:   cal_r.b1_b2   <= cfg_pwdata;
        REG_MC_MD:   cal_r.mc_md   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_AC1_AC2: cfg_prdata = cal_r.ac1_ac2;
      REG_AC3_AC4: cfg_prdata = cal_r.ac3_ac4;
      REG_AC5_AC6: cfg_prdata = cal_r.ac5_ac6;
      REG_B1_B2:   cfg_prdata = cal_r.b1_b2;
      REG_MC_MD:   cfg_prdata = cal_r.mc_md;
      default:     cfg_prdata = '0;
    endcase
  end

  bsc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  bsc_seq u_seq (
    .clk(clk), .rst_n(rst_n), .cal(cal_r),
    .in_ch(in_ch), .out_ch(out_ch), .dreq(dreq), .drsp(drsp)
  );
endmodule
